// ===== hdl/lbp_pkg.sv =====
// Shared constants, register codes and transaction types for the LBP code stream.
package lbp_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int WIDTH_W     = 11;
   localparam int HEIGHT_W    = 13;
   localparam int PIX_W       = 8;
   localparam int CODE_W      = 8;
   localparam int ADDR_W      = 3;
   localparam int DATA_W      = 32;
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

   // Register index, taken from paddr[2]
   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } lbp_reg_type;

   // One pixel on its way from the line-store read to the window
   typedef struct packed {
      logic             valid;
      logic             row_ge1;
      logic             row_ge2;
      logic             col_first;
      logic             col_ge1;
      logic             col_last;
      logic             row_is_last;
      logic             fwd;
      logic [PIX_W-1:0] fwd_upper;
      logic [PIX_W-1:0] fwd_middle;
      logic [PIX_W-1:0] low;
      logic [COL_W-1:0] idx;
   } lbp_item_type;

   // Line-store write-back
   typedef struct packed {
      logic             we;
      logic [COL_W-1:0] addr;
      logic [PIX_W-1:0] upper_data;
      logic [PIX_W-1:0] middle_data;
   } lbp_wr_type;

   typedef struct packed {
      logic [CODE_W-1:0] lbp_code;
      logic              end_of_row;
      logic              last_code;
   } lbp_rsp_payload_type;

   typedef struct packed {
      logic                valid;
      lbp_rsp_payload_type payload;
   } lbp_res_type;

endpackage

// ===== hdl/lbp_channels.sv =====
// Handshake interfaces for the pixel request and code response channels.
interface lbp_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] pixel_value;

   modport source (output valid, output req_type, output pixel_value, input ready);
   modport sink   (input valid, input req_type, input pixel_value, output ready);
endinterface

interface lbp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] lbp_code;
   logic       end_of_row;
   logic       last_code;

   modport source (output valid, output lbp_code, output end_of_row, output last_code,
                   input ready);
   modport sink   (input valid, input lbp_code, input end_of_row, input last_code,
                   output ready);
endinterface

// ===== hdl/lbp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module lbp_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/lbp_window.sv =====
// 3x3 window, line-store write-back and LBP code generation.
module lbp_window
   import lbp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  lbp_item_type     item,
   input  logic [PIX_W-1:0] upper_rdata,
   input  logic [PIX_W-1:0] middle_rdata,
   output lbp_wr_type       wr,
   output lbp_res_type      res_a,
   output lbp_res_type      res_b
);

   // [row: upper, middle, lower][col: left, centre, right]
   typedef logic [2:0][2:0][PIX_W-1:0] win_type;

   win_type          window_ff;
   win_type          window_in;
   win_type          win_a;
   win_type          win_b;
   logic [PIX_W-1:0] upper_raw;
   logic [PIX_W-1:0] middle_raw;
   logic [PIX_W-1:0] upper_px;
   logic [PIX_W-1:0] middle_px;

   function automatic win_type shift_col(input win_type w, input logic [PIX_W-1:0] up,
                                         input logic [PIX_W-1:0] mid,
                                         input logic [PIX_W-1:0] low);
      win_type s;
      for (int k = 0; k < 3; k++) begin
         s[k][0] = w[k][1];
         s[k][1] = w[k][2];
      end
      s[0][2] = up;
      s[1][2] = mid;
      s[2][2] = low;
      return s;
   endfunction

   // Bit set where the neighbour is at least the centre
   function automatic logic [CODE_W-1:0] win_code(input win_type w);
      logic [7:0][PIX_W-1:0] nb;
      logic [CODE_W-1:0]     code;
      nb[0] = w[1][0];
      nb[1] = w[2][0];
      nb[2] = w[2][1];
      nb[3] = w[2][2];
      nb[4] = w[1][2];
      nb[5] = w[0][2];
      nb[6] = w[0][1];
      nb[7] = w[0][0];
      for (int k = 0; k < 8; k++) begin
         code[k] = (nb[k] >= w[1][1]);
      end
      return code;
   endfunction

   // Pick forwarded data where the previous pixel wrote the same entry
   always_comb begin
      upper_raw  = item.fwd ? item.fwd_upper  : upper_rdata;
      middle_raw = item.fwd ? item.fwd_middle : middle_rdata;
      upper_px   = item.row_ge2 ? upper_raw  : '0;
      middle_px  = item.row_ge1 ? middle_raw : '0;
   end

   // Age the column: the middle row moves up, the new pixel goes in
   always_comb begin
      wr.we          = item.valid;
      wr.addr        = item.idx;
      wr.upper_data  = middle_raw;
      wr.middle_data = item.low;
   end

   // Window after the pixel, and after the zero column past the row end
   always_comb begin
      win_a = shift_col(item.col_first ? win_type'('0) : window_ff,
                        upper_px, middle_px, item.low);
      win_b = shift_col(win_a, '0, '0, '0);

      res_a.valid              = item.valid && item.row_ge1 && item.col_ge1;
      res_a.payload.lbp_code   = win_code(win_a);
      res_a.payload.end_of_row = 1'b0;
      res_a.payload.last_code  = 1'b0;

      res_b.valid              = item.valid && item.row_ge1 && item.col_last;
      res_b.payload.lbp_code   = win_code(win_b);
      res_b.payload.end_of_row = 1'b1;
      res_b.payload.last_code  = item.row_is_last;

      window_in = (item.row_ge1 && item.col_last) ? win_b : win_a;
   end

   // Hold the window; clear on reset and restart
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         window_ff <= '0;
      end else if (item.valid) begin
         window_ff <= window_in;
      end
   end

endmodule

// ===== hdl/lbp_rsp_fifo.sv =====
// Response queue taking up to two codes per cycle and releasing one while rsp.ready is high.
module lbp_rsp_fifo
   import lbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  lbp_res_type           push_a,
   input  lbp_res_type           push_b,
   output logic [FIFO_CNT_W-1:0] count,
   lbp_rsp_if.source             rsp
);

   lbp_rsp_payload_type         fifo_mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]       wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]       wr_ptr_in;
   logic [FIFO_PTR_W-1:0]       rd_ptr_ff;
   logic [FIFO_PTR_W-1:0]       rd_ptr_in;
   logic [FIFO_CNT_W-1:0]       count_ff;
   logic [FIFO_CNT_W-1:0]       count_in;
   logic [1:0]                  push_n;
   logic                        pop;
   lbp_rsp_payload_type         head;

   assign head = fifo_mem[rd_ptr_ff];

   // Head of queue drives the channel
   always_comb begin
      rsp.valid      = (count_ff != '0);
      rsp.lbp_code   = head.lbp_code;
      rsp.end_of_row = head.end_of_row;
      rsp.last_code  = head.last_code;
      count          = count_ff;
   end

   // Advance pointers and fill count
   always_comb begin
      pop       = rsp.valid && rsp.ready;
      push_n    = {1'b0, push_a.valid} + {1'b0, push_b.valid};
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the codes in order: in-row code first, row-end code second
   always_ff @(posedge clock) begin
      if (push_a.valid) begin
         fifo_mem[wr_ptr_ff] <= push_a.payload;
         if (push_b.valid) begin
            fifo_mem[wr_ptr_ff + FIFO_PTR_W'(1)] <= push_b.payload;
         end
      end else if (push_b.valid) begin
         fifo_mem[wr_ptr_ff] <= push_b.payload;
      end
   end

endmodule

// ===== hdl/lbp_3x3_code_stream.sv =====
// Top level: 3x3 local binary pattern codes over a raster pixel stream.
//
//   channel  direction  handshake           payload
//   req      in         valid/ready         req_type, pixel_value
//   rsp      out        valid/ready         lbp_code, end_of_row, last_code
//   csr      in         APB psel/penable    image_width @0x0, image_height @0x4
//
// One pixel per clock while req.ready is high: each line store takes one read
// and one write-back per cycle; the read of a pixel's column is issued on
// acceptance and written back the next cycle, with forwarding when the same
// entry is read again at once. A code passes the item register, then the
// response queue. Reset is synchronous; the line stores are not cleared, rows
// above the image are masked by the row counter. req.ready drops while the
// response queue lacks room for two codes per pixel in flight.
module lbp_3x3_code_stream
   import lbp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   lbp_req_if.sink           req,
   lbp_rsp_if.source         rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   logic [WIDTH_W-1:0]    image_width_ff;
   logic [HEIGHT_W-1:0]   image_height_ff;
   logic [COL_W-1:0]      col_ff;
   logic [COL_W-1:0]      col_in;
   logic [HEIGHT_W-1:0]   row_ff;
   logic [HEIGHT_W-1:0]   row_in;
   logic [WIDTH_W-1:0]    eff_width;
   logic [HEIGHT_W-1:0]   eff_height;
   logic                  col_last;
   logic                  accept;
   logic                  csr_write;
   lbp_reg_type           reg_sel;
   lbp_item_type          item_ff;
   lbp_item_type          item_in;
   lbp_wr_type            wr;
   lbp_res_type           res_a;
   lbp_res_type           res_b;
   logic [PIX_W-1:0]      upper_rdata;
   logic [PIX_W-1:0]      middle_rdata;
   logic [FIFO_CNT_W-1:0] fifo_count;
   logic [FIFO_CNT_W:0]   fill_need;

   // Register port
   assign pready    = 1'b1;
   assign reg_sel   = lbp_reg_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      unique case (reg_sel)
         REG_IMAGE_WIDTH:  prdata = DATA_W'(image_width_ff);
         REG_IMAGE_HEIGHT: prdata = DATA_W'(image_height_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (reg_sel)
            REG_IMAGE_WIDTH:  image_width_ff  <= pwdata[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: image_height_ff <= pwdata[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the geometry
   always_comb begin
      if (image_width_ff == '0) begin
         eff_width = WIDTH_W'(1);
      end else if (image_width_ff > WIDTH_W'(MAX_WIDTH)) begin
         eff_width = WIDTH_W'(MAX_WIDTH);
      end else begin
         eff_width = image_width_ff;
      end
      eff_height = (image_height_ff == '0) ? HEIGHT_W'(1) : image_height_ff;
   end

   // Accept while the queue can take every code of the pixels in flight
   assign fill_need = (FIFO_CNT_W + 1)'(fifo_count)
                    + (item_ff.valid ? (FIFO_CNT_W + 1)'(2) : '0)
                    + (FIFO_CNT_W + 1)'(2);
   assign req.ready = (fill_need <= (FIFO_CNT_W + 1)'(FIFO_DEPTH));
   assign accept    = req.valid && req.ready;

   // Position of the incoming pixel
   assign col_last = (WIDTH_W'(col_ff) + WIDTH_W'(1)) >= eff_width;

   always_comb begin
      item_in.valid       = accept;
      item_in.row_ge1     = (row_ff != '0);
      item_in.row_ge2     = (row_ff >= HEIGHT_W'(2));
      item_in.col_first   = (col_ff == '0);
      item_in.col_ge1     = (col_ff != '0);
      item_in.col_last    = col_last;
      item_in.row_is_last = (row_ff == eff_height);
      item_in.low         = (row_ff < eff_height && !req.req_type) ? req.pixel_value : '0;
      item_in.idx         = col_ff;
      item_in.fwd         = wr.we && (wr.addr == col_ff);
      item_in.fwd_upper   = wr.upper_data;
      item_in.fwd_middle  = wr.middle_data;
   end

   // Advance column and row; wrap after the padding row
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = (row_ff >= eff_height) ? '0 : row_ff + HEIGHT_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         col_ff        <= '0;
         row_ff        <= '0;
         item_ff.valid <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         item_ff.valid <= item_in.valid;
      end
      // Pixel payload for the window stage
      if (accept) begin
         item_ff.row_ge1     <= item_in.row_ge1;
         item_ff.row_ge2     <= item_in.row_ge2;
         item_ff.col_first   <= item_in.col_first;
         item_ff.col_ge1     <= item_in.col_ge1;
         item_ff.col_last    <= item_in.col_last;
         item_ff.row_is_last <= item_in.row_is_last;
         item_ff.fwd         <= item_in.fwd;
         item_ff.fwd_upper   <= item_in.fwd_upper;
         item_ff.fwd_middle  <= item_in.fwd_middle;
         item_ff.low         <= item_in.low;
         item_ff.idx         <= item_in.idx;
      end
   end

   // Line stores
   lbp_ram #(.DEPTH(MAX_WIDTH), .WIDTH(PIX_W)) u_upper_store (
      .clock (clock),
      .we    (wr.we),
      .waddr (wr.addr),
      .wdata (wr.upper_data),
      .re    (accept),
      .raddr (col_ff),
      .rdata (upper_rdata)
   );

   lbp_ram #(.DEPTH(MAX_WIDTH), .WIDTH(PIX_W)) u_middle_store (
      .clock (clock),
      .we    (wr.we),
      .waddr (wr.addr),
      .wdata (wr.middle_data),
      .re    (accept),
      .raddr (col_ff),
      .rdata (middle_rdata)
   );

   lbp_window u_window (
      .clock        (clock),
      .reset        (reset),
      .clear        (csr_write),
      .item         (item_ff),
      .upper_rdata  (upper_rdata),
      .middle_rdata (middle_rdata),
      .wr           (wr),
      .res_a        (res_a),
      .res_b        (res_b)
   );

   lbp_rsp_fifo u_rsp_fifo (
      .clock  (clock),
      .reset  (reset),
      .push_a (res_a),
      .push_b (res_b),
      .count  (fifo_count),
      .rsp    (rsp)
   );

   // Checks
   a_fifo_no_overflow : assert property (@(posedge clock) disable iff (reset)
      fifo_count <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("response queue overflow");

   a_fwd_only_narrow : assert property (@(posedge clock) disable iff (reset)
      (item_ff.valid && item_ff.fwd) |-> (eff_width == WIDTH_W'(1)))
      else $error("forwarding on an image wider than one column");

   a_last_is_row_end : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.last_code) |-> rsp.end_of_row)
      else $error("final code not at a row end");

   a_restart_clears : assert property (@(posedge clock) disable iff (reset)
      csr_write |=> (col_ff == '0 && row_ff == '0 && !item_ff.valid))
      else $error("register write did not restart the image");

endmodule
